>>> design/tpc_pkg.sv
`default_nettype none
package tpc_pkg;

  // raw converter sample width
  localparam int SAMPLE_BITS = 12;

  // shared divider geometry
  localparam int DIVIDEND_W = 2 * SAMPLE_BITS;
  localparam int DIVISOR_W  = SAMPLE_BITS;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // configuration register indexes
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t REG_GROUP_LENGTH   = 3'd0;
  localparam cfg_index_t REG_CORNER_SAMPLES = 3'd1;
  localparam cfg_index_t REG_CAL_PRESSURE   = 3'd2;
  localparam cfg_index_t REG_RUN_PRESSURE   = 3'd3;
  localparam cfg_index_t REG_PANEL_WIDTH    = 3'd4;
  localparam cfg_index_t REG_PANEL_HEIGHT   = 3'd5;

  // configuration reset values
  localparam logic [3:0]  RST_GROUP_LENGTH   = 4'd4;
  localparam logic [5:0]  RST_CORNER_SAMPLES = 6'd20;
  localparam logic [11:0] RST_CAL_PRESSURE   = 12'd150;
  localparam logic [11:0] RST_RUN_PRESSURE   = 12'd500;
  localparam logic [11:0] RST_PANEL_WIDTH    = 12'd240;
  localparam logic [11:0] RST_PANEL_HEIGHT   = 12'd320;

  // result status codes
  typedef logic [2:0] status_t;
  localparam status_t STATUS_KEPT       = 3'd0;
  localparam status_t STATUS_WEAK       = 3'd1;
  localparam status_t STATUS_FIRST_DONE = 3'd2;
  localparam status_t STATUS_CALIBRATED = 3'd3;
  localparam status_t STATUS_POINT      = 3'd4;
  localparam status_t STATUS_POINT_WEAK = 3'd5;
  localparam status_t STATUS_MAP_ERROR  = 3'd6;

  // calibration phases
  localparam logic [1:0] PHASE_TOP_LEFT = 2'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GROUP_X,
    S_GROUP_Y,
    S_DECIDE,
    S_CORNER_X,
    S_CORNER_Y,
    S_MUL,
    S_MAP_START,
    S_MAP_DIV,
    S_RESULT
  } seq_state_t;

  typedef struct packed {
    logic    command;
    sample_t raw_x;
    sample_t raw_y;
    sample_t raw_pressure;
  } sample_req_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [11:0]        group_pressure_out;
    logic [5:0]         samples_taken;
    sample_t            left_raw_x;
    sample_t            top_raw_y;
    sample_t            right_raw_x;
    sample_t            bottom_raw_y;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> design/tpc_div.sv
`default_nettype none
module tpc_div (
  input  logic               clk,
  input  logic               rst,
  input  tpc_pkg::div_req_t  req,
  output tpc_pkg::div_rsp_t  rsp
);

  logic                            busy;
  logic                            done;
  logic [tpc_pkg::DIV_CNT_W-1:0]   count;
  logic [tpc_pkg::DIVISOR_W-1:0]   rem;
  logic [tpc_pkg::DIVIDEND_W-1:0]  quo;
  logic [tpc_pkg::DIVISOR_W-1:0]   divisor;
  logic [tpc_pkg::DIVISOR_W:0]     shifted;
  logic [tpc_pkg::DIVISOR_W:0]     diff;
  logic                            fits;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, quo[tpc_pkg::DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == tpc_pkg::DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[tpc_pkg::DIVISOR_W-1:0] : shifted[tpc_pkg::DIVISOR_W-1:0];
      quo <= {quo[tpc_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

>>> design/touch_two_point_calibrator.sv
// two-point touch calibrator
//
// sample channel (sample_valid / sample_ready / sample): one raw reading or a
// restart command per request. readings form groups: the first reading is
// dropped, the next group_length are averaged. while calibrating, groups with
// enough pressure are averaged into the top-left, then bottom-right corner;
// afterwards strong groups map to screen coordinates (error on equal corners).
// result channel (result_valid / result_ready / result): one request per
// completed group, held in an output register until taken.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready,
// meant to be written only while the block is idle.
// sequencing: a request that does not complete a group leaves the block idle.
// a completing request runs through one shared 24-step restoring divider:
// the group averages x then y for a kept, weak, weak-point or error group; a
// closing corner adds the corner averages x then y; a mapped point adds a
// multiply and a divide per axis. sample_ready is low until the result is
// registered. a stalled receiver only blocks once the next result is ready.
// reset (synchronous) restores register defaults and the top-left phase.
`default_nettype none
module touch_two_point_calibrator (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  tpc_pkg::sample_req_t   sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output tpc_pkg::result_t       result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  tpc_pkg::cfg_index_t    cfg_index,
  input  logic [11:0]            cfg_data
);

  // configuration registers
  logic [3:0]  group_length;
  logic [5:0]  corner_samples;
  logic [11:0] calibrate_pressure_min;
  logic [11:0] run_pressure_min;
  logic [11:0] panel_width;
  logic [11:0] panel_height;

  // sequencer and datapath state
  tpc_pkg::seq_state_t state, state_next;
  logic [1:0]          phase, phase_next;
  logic [3:0]          group_position, group_position_next;
  logic [15:0]         group_sum_x, group_sum_x_next;
  logic [15:0]         group_sum_y, group_sum_y_next;
  logic [11:0]         group_pressure, group_pressure_next;
  logic [5:0]          corner_count, corner_count_next;
  logic [17:0]         corner_sum_x, corner_sum_x_next;
  logic [17:0]         corner_sum_y, corner_sum_y_next;
  logic [11:0]         corner_values [4];
  logic [11:0]         corner_values_next [4];
  logic [11:0]         avg_x, avg_x_next;
  logic [11:0]         avg_y, avg_y_next;
  logic signed [15:0]  px, px_next;
  logic signed [15:0]  py, py_next;
  tpc_pkg::status_t    status_r, status_r_next;
  logic [5:0]          taken, taken_next;
  logic                axis, axis_next;
  logic signed [25:0]  prod, prod_next;
  logic                neg, neg_next;
  logic                result_valid_next;
  tpc_pkg::result_t    result_next;

  // combinational helpers
  logic                accept;
  logic [3:0]          len;
  logic [5:0]          need;
  logic [15:0]         sum_x_add;
  logic [15:0]         sum_y_add;
  logic [5:0]          count_inc;
  logic [17:0]         csum_x_add;
  logic [17:0]         csum_y_add;
  logic                corners_equal;
  logic [11:0]         map_v, map_lo, map_hi, map_span;
  logic signed [12:0]  map_d, map_s, map_h;
  logic [25:0]         prod_abs;
  logic [12:0]         h_abs;
  logic signed [25:0]  q_s;
  logic signed [25:0]  map_r;
  logic signed [15:0]  map_sat;
  tpc_pkg::div_req_t   div_req;
  tpc_pkg::div_rsp_t   div_rsp;

  tpc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_length           <= tpc_pkg::RST_GROUP_LENGTH;
      corner_samples         <= tpc_pkg::RST_CORNER_SAMPLES;
      calibrate_pressure_min <= tpc_pkg::RST_CAL_PRESSURE;
      run_pressure_min       <= tpc_pkg::RST_RUN_PRESSURE;
      panel_width            <= tpc_pkg::RST_PANEL_WIDTH;
      panel_height           <= tpc_pkg::RST_PANEL_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpc_pkg::REG_GROUP_LENGTH:   group_length           <= cfg_data[3:0];
        tpc_pkg::REG_CORNER_SAMPLES: corner_samples         <= cfg_data[5:0];
        tpc_pkg::REG_CAL_PRESSURE:   calibrate_pressure_min <= cfg_data;
        tpc_pkg::REG_RUN_PRESSURE:   run_pressure_min       <= cfg_data;
        tpc_pkg::REG_PANEL_WIDTH:    panel_width            <= cfg_data;
        tpc_pkg::REG_PANEL_HEIGHT:   panel_height           <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero counts act as one; a 6-bit count never exceeds the corner maximum
  assign len  = (group_length == 4'd0) ? 4'd1 : group_length;
  assign need = (corner_samples == 6'd0) ? 6'd1 : corner_samples;

  assign sample_ready = (state == tpc_pkg::S_IDLE);
  assign accept       = sample_valid && sample_ready;

  assign sum_x_add  = group_sum_x + 16'(sample.raw_x);
  assign sum_y_add  = group_sum_y + 16'(sample.raw_y);
  assign count_inc  = corner_count + 6'd1;
  assign csum_x_add = corner_sum_x + 18'(avg_x);
  assign csum_y_add = corner_sum_y + 18'(avg_y);

  assign corners_equal = (corner_values[0] == corner_values[2]) ||
                         (corner_values[1] == corner_values[3]);

  // mapping operands for the axis in work
  assign map_v    = axis ? avg_y : avg_x;
  assign map_lo   = axis ? corner_values[1] : corner_values[0];
  assign map_hi   = axis ? corner_values[3] : corner_values[2];
  assign map_span = axis ? panel_height : panel_width;
  assign map_d    = $signed({1'b0, map_v}) - $signed({1'b0, map_lo});
  assign map_s    = $signed({1'b0, map_span}) - 13'sd1;
  assign map_h    = $signed({1'b0, map_hi}) - $signed({1'b0, map_lo});

  // divide magnitudes, put the sign back, then add one to the truncated quotient
  assign prod_abs = prod[25] ? 26'(-prod) : 26'(prod);
  assign h_abs    = map_h[12] ? 13'(-map_h) : 13'(map_h);
  assign q_s      = $signed({2'b00, div_rsp.quotient});
  assign map_r    = neg ? (26'sd1 - q_s) : (q_s + 26'sd1);

  always_comb begin
    if (map_r > 26'sd32767) begin
      map_sat = 16'sh7fff;
    end else if (map_r < -26'sd32768) begin
      map_sat = 16'sh8000;
    end else begin
      map_sat = map_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tpc_pkg::S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= tpc_pkg::PHASE_TOP_LEFT;
      group_position <= '0;
      group_sum_x    <= '0;
      group_sum_y    <= '0;
      group_pressure <= '0;
      corner_count   <= '0;
      corner_sum_x   <= '0;
      corner_sum_y   <= '0;
      for (int i = 0; i < 4; i++) begin
        corner_values[i] <= '0;
      end
    end else begin
      phase          <= phase_next;
      group_position <= group_position_next;
      group_sum_x    <= group_sum_x_next;
      group_sum_y    <= group_sum_y_next;
      group_pressure <= group_pressure_next;
      corner_count   <= corner_count_next;
      corner_sum_x   <= corner_sum_x_next;
      corner_sum_y   <= corner_sum_y_next;
      corner_values  <= corner_values_next;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    avg_x    <= avg_x_next;
    avg_y    <= avg_y_next;
    px       <= px_next;
    py       <= py_next;
    status_r <= status_r_next;
    taken    <= taken_next;
    axis     <= axis_next;
    prod     <= prod_next;
    neg      <= neg_next;
    result   <= result_next;
  end

  always_comb begin
    state_next          = state;
    phase_next          = phase;
    group_position_next = group_position;
    group_sum_x_next    = group_sum_x;
    group_sum_y_next    = group_sum_y;
    group_pressure_next = group_pressure;
    corner_count_next   = corner_count;
    corner_sum_x_next   = corner_sum_x;
    corner_sum_y_next   = corner_sum_y;
    corner_values_next  = corner_values;
    avg_x_next          = avg_x;
    avg_y_next          = avg_y;
    px_next             = px;
    py_next             = py;
    status_r_next       = status_r;
    taken_next          = taken;
    axis_next           = axis;
    prod_next           = prod;
    neg_next            = neg;
    result_valid_next   = result_valid && !result_ready;
    result_next         = result;
    div_req             = '0;

    case (state)
      tpc_pkg::S_IDLE: begin
        if (accept) begin
          if (sample.command) begin
            // restart: clear calibration, keep registers
            phase_next          = tpc_pkg::PHASE_TOP_LEFT;
            group_position_next = '0;
            group_sum_x_next    = '0;
            group_sum_y_next    = '0;
            group_pressure_next = '0;
            corner_count_next   = '0;
            corner_sum_x_next   = '0;
            corner_sum_y_next   = '0;
            for (int i = 0; i < 4; i++) begin
              corner_values_next[i] = '0;
            end
          end else if (group_position == 4'd0) begin
            // discarded first reading
            group_position_next = 4'd1;
            group_sum_x_next    = '0;
            group_sum_y_next    = '0;
          end else begin
            if (group_position == 4'd1) begin
              group_pressure_next = sample.raw_pressure;
            end
            group_sum_x_next = sum_x_add;
            group_sum_y_next = sum_y_add;
            if (group_position < len) begin
              group_position_next = group_position + 4'd1;
            end else begin
              // group complete; sums stay for the divider, next group clears them
              group_position_next = '0;
              div_req.start    = 1'b1;
              div_req.dividend = 24'(sum_x_add);
              div_req.divisor  = 12'(len);
              state_next       = tpc_pkg::S_GROUP_X;
            end
          end
        end
      end

      tpc_pkg::S_GROUP_X: begin
        if (div_rsp.done) begin
          avg_x_next       = div_rsp.quotient[11:0];
          div_req.start    = 1'b1;
          div_req.dividend = 24'(group_sum_y);
          div_req.divisor  = 12'(len);
          state_next       = tpc_pkg::S_GROUP_Y;
        end
      end

      tpc_pkg::S_GROUP_Y: begin
        if (div_rsp.done) begin
          avg_y_next = div_rsp.quotient[11:0];
          state_next = tpc_pkg::S_DECIDE;
        end
      end

      tpc_pkg::S_DECIDE: begin
        px_next = '0;
        py_next = '0;
        if (!phase[1]) begin
          if (group_pressure > calibrate_pressure_min) begin
            corner_sum_x_next = csum_x_add;
            corner_sum_y_next = csum_y_add;
            corner_count_next = count_inc;
            taken_next        = count_inc;
            if (count_inc >= need) begin
              // corner closes: average the corner sums
              status_r_next    = (phase == tpc_pkg::PHASE_TOP_LEFT) ?
                                 tpc_pkg::STATUS_FIRST_DONE : tpc_pkg::STATUS_CALIBRATED;
              div_req.start    = 1'b1;
              div_req.dividend = 24'(csum_x_add);
              div_req.divisor  = 12'(need);
              state_next       = tpc_pkg::S_CORNER_X;
            end else begin
              status_r_next = tpc_pkg::STATUS_KEPT;
              state_next    = tpc_pkg::S_RESULT;
            end
          end else begin
            status_r_next = tpc_pkg::STATUS_WEAK;
            taken_next    = corner_count;
            state_next    = tpc_pkg::S_RESULT;
          end
        end else begin
          taken_next = '0;
          if (group_pressure > run_pressure_min) begin
            if (corners_equal) begin
              status_r_next = tpc_pkg::STATUS_MAP_ERROR;
              state_next    = tpc_pkg::S_RESULT;
            end else begin
              status_r_next = tpc_pkg::STATUS_POINT;
              axis_next     = 1'b0;
              state_next    = tpc_pkg::S_MUL;
            end
          end else begin
            status_r_next = tpc_pkg::STATUS_POINT_WEAK;
            state_next    = tpc_pkg::S_RESULT;
          end
        end
      end

      tpc_pkg::S_CORNER_X: begin
        if (div_rsp.done) begin
          corner_values_next[{phase[0], 1'b0}] = div_rsp.quotient[11:0];
          div_req.start    = 1'b1;
          div_req.dividend = 24'(corner_sum_y);
          div_req.divisor  = 12'(need);
          state_next       = tpc_pkg::S_CORNER_Y;
        end
      end

      tpc_pkg::S_CORNER_Y: begin
        if (div_rsp.done) begin
          corner_values_next[{phase[0], 1'b1}] = div_rsp.quotient[11:0];
          phase_next        = phase + 2'd1;
          corner_count_next = '0;
          corner_sum_x_next = '0;
          corner_sum_y_next = '0;
          state_next        = tpc_pkg::S_RESULT;
        end
      end

      tpc_pkg::S_MUL: begin
        prod_next  = map_d * map_s;
        state_next = tpc_pkg::S_MAP_START;
      end

      tpc_pkg::S_MAP_START: begin
        neg_next         = prod[25] ^ map_h[12];
        div_req.start    = 1'b1;
        div_req.dividend = prod_abs[23:0];
        div_req.divisor  = h_abs[11:0];
        state_next       = tpc_pkg::S_MAP_DIV;
      end

      tpc_pkg::S_MAP_DIV: begin
        if (div_rsp.done) begin
          if (!axis) begin
            px_next    = map_sat;
            axis_next  = 1'b1;
            state_next = tpc_pkg::S_MUL;
          end else begin
            py_next    = map_sat;
            state_next = tpc_pkg::S_RESULT;
          end
        end
      end

      tpc_pkg::S_RESULT: begin
        // wait for the output register to free up
        if (!result_valid || result_ready) begin
          result_valid_next              = 1'b1;
          result_next.status             = status_r;
          result_next.point_x            = px;
          result_next.point_y            = py;
          result_next.group_pressure_out = group_pressure;
          result_next.samples_taken      = taken;
          result_next.left_raw_x         = corner_values[0];
          result_next.top_raw_y          = corner_values[1];
          result_next.right_raw_x        = corner_values[2];
          result_next.bottom_raw_y       = corner_values[3];
          state_next                     = tpc_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = tpc_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> design/tpc_checker.sv
`default_nettype none
module tpc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  sample_valid,
  input logic                  sample_ready,
  input tpc_pkg::sample_req_t  sample,
  input logic                  result_valid,
  input logic                  result_ready,
  input tpc_pkg::result_t      result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // out of reset: idle, nothing pending
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) && !rst |-> sample_ready && !result_valid)
    else $error("not idle after reset");

  // a restart request never starts the sequencer
  a_restart_quick: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && sample.command |=> sample_ready)
    else $error("restart left the block busy");

  // only mapped points carry coordinates
  a_point_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != tpc_pkg::STATUS_POINT |->
      result.point_x == 16'sd0 && result.point_y == 16'sd0)
    else $error("coordinates without a point");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status <= tpc_pkg::STATUS_MAP_ERROR)
    else $error("unused status code");

endmodule

bind touch_two_point_calibrator tpc_checker u_tpc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .sample       (sample),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
`default_nettype wire
